[rtl/core/bitmap_block_inode_allocator_macros.svh]
// Assertion macros shared by the allocator checks.
`ifndef BITMAP_BLOCK_INODE_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_INODE_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BBIA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbia check failed");

// Next-cycle implication.
`define BBIA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbia check failed");

`endif

[rtl/core/bbia_pkg.sv]
// Shared constants, codes and helpers of the block/inode bitmap allocator.
package bbia_pkg;

   localparam int MAP_BYTES  = 4096;
   localparam int WORD_W     = 32;
   localparam int MAP_BITS   = MAP_BYTES * 8;
   localparam int WORDS      = MAP_BITS / WORD_W;
   localparam int SUM_WORDS  = WORDS / WORD_W;
   localparam int BIT_W      = $clog2(MAP_BITS);
   localparam int WSEL_W     = $clog2(WORD_W);
   localparam int WORD_IDX_W = $clog2(WORDS);
   localparam int SUM_IDX_W  = $clog2(SUM_WORDS);
   localparam int DATA_AW    = WORD_IDX_W + 1;
   localparam int SUM_AW     = SUM_IDX_W + 1;
   localparam int DATA_DEPTH = 2 * WORDS;
   localparam int SUM_DEPTH  = 2 * SUM_WORDS;

   localparam int NUMBER_W   = 32;
   localparam int START_W    = 24;
   localparam int ALLOC_W    = 25;
   localparam int STATUS_W   = 2;
   localparam int RSP_W      = 32;
   localparam int CSR_AW     = 3;

   localparam logic REG_DATA_START = 1'b0;

   typedef enum logic [1:0] {
      OP_ALLOC_BLOCK = 2'd0,
      OP_FREE_BLOCK  = 2'd1,
      OP_ALLOC_INODE = 2'd2,
      OP_FREE_INODE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   // Lowest clear bit of a word; zero when none is clear.
   function automatic logic [WSEL_W-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [WSEL_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) r = WSEL_W'(i);
      end
      return r;
   endfunction

endpackage

[rtl/core/bbia_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module bbia_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

endmodule

[rtl/core/bitmap_block_inode_allocator.sv]
// Top level: block and inode bitmap first-fit allocator.
//
// Request channel (req_*): req_tuser carries the operation (allocate block, free block,
// allocate inode, free inode), req_tdata the block or inode number to free.
// Response channel (rsp_*): one transaction per request, allocated number in
// rsp_tdata[24:0] and status in rsp_tdata[26:25] (done, map full, invalid free).
// Block allocations return the bit index plus the data start register (csr address 0).
//
// Each map is kept as 32-bit words in one shared RAM, with a summary RAM holding a
// word-full bit per word and a 32-bit top register per map holding a summary-full bit.
// An allocation walks top, summary word, data word via the summary-read, word, bit and
// output states; a free does one read-modify-write of the data and summary words via
// the free-read, free-write and output states. A full map goes straight to the output
// state, an invalid free after free-read. One request is in flight at a time.
//
// After reset a clearing pass writes all 2048 map words (bit 0 of each map preset as
// reserved); req_tready stays low during that pass. A new request is accepted while
// the last response is still held; if rsp_tready is low the block waits with its next
// result until the output register frees.
module bitmap_block_inode_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bbia_pkg::NUMBER_W-1:0] req_tdata,   // number
   input  logic [1:0]                    req_tuser,   // op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bbia_pkg::RSP_W-1:0]    rsp_tdata,   // allocated[24:0], status[26:25], zeros
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bbia_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam int WB = bbia_pkg::WSEL_W;
   localparam int SB = bbia_pkg::WSEL_W + bbia_pkg::WORD_IDX_W - bbia_pkg::SUM_IDX_W;
   localparam int TB = bbia_pkg::BIT_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SUM_RD,
      S_WORD,
      S_BIT,
      S_FREE_RD,
      S_FREE_WR,
      S_OUT
   } state_type;

   state_type                           state_ff;
   logic [bbia_pkg::DATA_AW-1:0]        clear_cnt_ff;
   logic [bbia_pkg::WORD_W-1:0]         top_ff [2];
   logic [1:0]                          op_ff;
   logic [TB-1:0]                       idx_ff;
   logic                                invalid_ff;
   logic [bbia_pkg::SUM_IDX_W-1:0]      sidx_ff;
   logic [WB-1:0]                       widx_ff;
   logic [bbia_pkg::WORD_W-1:0]         sumword_ff;
   logic [bbia_pkg::ALLOC_W-1:0]        res_alloc_ff;
   logic [bbia_pkg::STATUS_W-1:0]       res_status_ff;
   logic                                rsp_valid_ff;
   logic [bbia_pkg::RSP_W-1:0]          rsp_data_ff;
   logic [bbia_pkg::START_W-1:0]        start_ff;

   logic                                req_fire;
   logic [bbia_pkg::NUMBER_W:0]         blk_diff;
   logic [bbia_pkg::NUMBER_W-1:0]       free_idx;
   logic                                free_invalid;
   logic [bbia_pkg::WORD_W-1:0]         top_sel;
   logic                                sel;

   logic                                data_we;
   logic [bbia_pkg::DATA_AW-1:0]        data_waddr;
   logic [bbia_pkg::WORD_W-1:0]         data_wdata;
   logic [bbia_pkg::DATA_AW-1:0]        data_raddr;
   logic [bbia_pkg::WORD_W-1:0]         data_rdata;
   logic                                sum_we;
   logic [bbia_pkg::SUM_AW-1:0]         sum_waddr;
   logic [bbia_pkg::WORD_W-1:0]         sum_wdata;
   logic [bbia_pkg::SUM_AW-1:0]         sum_raddr;
   logic [bbia_pkg::WORD_W-1:0]         sum_rdata;

   logic [WB-1:0]                       word_pick;
   logic [WB-1:0]                       bit_pick;
   logic [bbia_pkg::WORD_W-1:0]         set_word;
   logic                                word_full;
   logic [bbia_pkg::WORD_W-1:0]         set_sum;
   logic [TB-1:0]                       bit_index;
   logic [bbia_pkg::ALLOC_W-1:0]        alloc_value;
   logic                                csr_wr;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign sel        = op_ff[1];

   // free target validation
   assign blk_diff = {1'b0, req_tdata} - {{(bbia_pkg::NUMBER_W + 1 - bbia_pkg::START_W){1'b0}},
                                          start_ff};
   assign free_idx = (req_tuser == bbia_pkg::OP_FREE_BLOCK) ?
                     blk_diff[bbia_pkg::NUMBER_W-1:0] : req_tdata;
   assign free_invalid = ((req_tuser == bbia_pkg::OP_FREE_BLOCK) && blk_diff[bbia_pkg::NUMBER_W])
                      || (free_idx == '0)
                      || (free_idx[bbia_pkg::NUMBER_W-1:TB] != '0);
   assign top_sel = top_ff[req_tuser[1]];

   // allocation datapath
   assign word_pick   = bbia_pkg::first_zero(sum_rdata);
   assign bit_pick    = bbia_pkg::first_zero(data_rdata);
   assign set_word    = data_rdata | (bbia_pkg::WORD_W'(1) << bit_pick);
   assign word_full   = &set_word;
   assign set_sum     = sumword_ff | (word_full ? (bbia_pkg::WORD_W'(1) << widx_ff) : '0);
   assign bit_index   = {sidx_ff, widx_ff, bit_pick};
   assign alloc_value = (op_ff == bbia_pkg::OP_ALLOC_BLOCK) ?
                        bbia_pkg::ALLOC_W'(start_ff) + bbia_pkg::ALLOC_W'(bit_index) :
                        bbia_pkg::ALLOC_W'(bit_index);

   always_comb begin
      data_we    = 1'b0;
      data_waddr = '0;
      data_wdata = '0;
      data_raddr = '0;
      sum_we     = 1'b0;
      sum_waddr  = '0;
      sum_wdata  = '0;
      sum_raddr  = '0;
      case (state_ff)
         S_CLEAR: begin
            data_we    = 1'b1;
            data_waddr = clear_cnt_ff;
            data_wdata = (clear_cnt_ff[bbia_pkg::WORD_IDX_W-1:0] == '0) ?
                         bbia_pkg::WORD_W'(1) : '0;
            sum_we     = (clear_cnt_ff[bbia_pkg::DATA_AW-1:bbia_pkg::SUM_AW] == '0);
            sum_waddr  = clear_cnt_ff[bbia_pkg::SUM_AW-1:0];
         end
         S_SUM_RD: begin
            sum_raddr = {sel, sidx_ff};
         end
         S_WORD: begin
            data_raddr = {sel, sidx_ff, word_pick};
         end
         S_BIT: begin
            data_we    = 1'b1;
            data_waddr = {sel, sidx_ff, widx_ff};
            data_wdata = set_word;
            sum_we     = word_full;
            sum_waddr  = {sel, sidx_ff};
            sum_wdata  = set_sum;
         end
         S_FREE_RD: begin
            data_raddr = {sel, idx_ff[TB-1:WB]};
            sum_raddr  = {sel, idx_ff[TB-1:SB]};
         end
         S_FREE_WR: begin
            data_we    = 1'b1;
            data_waddr = {sel, idx_ff[TB-1:WB]};
            data_wdata = data_rdata & ~(bbia_pkg::WORD_W'(1) << idx_ff[WB-1:0]);
            sum_we     = 1'b1;
            sum_waddr  = {sel, idx_ff[TB-1:SB]};
            sum_wdata  = sum_rdata & ~(bbia_pkg::WORD_W'(1) << idx_ff[SB-1:WB]);
         end
         default: begin
         end
      endcase
   end

   bbia_ram #(
      .DEPTH (bbia_pkg::DATA_DEPTH),
      .WIDTH (bbia_pkg::WORD_W)
   ) u_data_ram (
      .clock (clock),
      .we    (data_we),
      .waddr (data_waddr),
      .wdata (data_wdata),
      .raddr (data_raddr),
      .rdata (data_rdata)
   );

   bbia_ram #(
      .DEPTH (bbia_pkg::SUM_DEPTH),
      .WIDTH (bbia_pkg::WORD_W)
   ) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_waddr),
      .wdata (sum_wdata),
      .raddr (sum_raddr),
      .rdata (sum_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_cnt_ff <= '0;
         top_ff[0]    <= '0;
         top_ff[1]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready && (state_ff != S_OUT)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clear_cnt_ff <= clear_cnt_ff + 1'b1;
               if (&clear_cnt_ff) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_fire) begin
                  op_ff      <= req_tuser;
                  idx_ff     <= free_idx[TB-1:0];
                  invalid_ff <= free_invalid;
                  sidx_ff    <= bbia_pkg::SUM_IDX_W'(bbia_pkg::first_zero(top_sel));
                  if (req_tuser[0]) begin
                     state_ff <= S_FREE_RD;
                  end else if (&top_sel) begin
                     res_alloc_ff  <= '0;
                     res_status_ff <= bbia_pkg::ST_FULL;
                     state_ff      <= S_OUT;
                  end else begin
                     state_ff <= S_SUM_RD;
                  end
               end
            end
            S_SUM_RD: begin
               state_ff <= S_WORD;
            end
            S_WORD: begin
               sumword_ff <= sum_rdata;
               widx_ff    <= word_pick;
               state_ff   <= S_BIT;
            end
            S_BIT: begin
               if (&set_sum) top_ff[sel][sidx_ff] <= 1'b1;
               res_alloc_ff  <= alloc_value;
               res_status_ff <= bbia_pkg::ST_DONE;
               state_ff      <= S_OUT;
            end
            S_FREE_RD: begin
               if (invalid_ff) begin
                  res_alloc_ff  <= '0;
                  res_status_ff <= bbia_pkg::ST_INVALID;
                  state_ff      <= S_OUT;
               end else begin
                  state_ff <= S_FREE_WR;
               end
            end
            S_FREE_WR: begin
               top_ff[sel][idx_ff[TB-1:SB]] <= 1'b0;
               res_alloc_ff  <= '0;
               res_status_ff <= bbia_pkg::ST_DONE;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {{(bbia_pkg::RSP_W - bbia_pkg::ALLOC_W - bbia_pkg::STATUS_W){1'b0}},
                                   res_status_ff, res_alloc_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite
                && (csr_paddr[bbia_pkg::CSR_AW-1] == bbia_pkg::REG_DATA_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
      end else if (csr_wr) begin
         start_ff <= csr_pwdata[bbia_pkg::START_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[bbia_pkg::CSR_AW-1] == bbia_pkg::REG_DATA_START) ?
                       {{(32 - bbia_pkg::START_W){1'b0}}, start_ff} : '0;

endmodule

[rtl/core/bbia_checker.sv]
// Port-level checks of the allocator, bound to the top level.
`include "bitmap_block_inode_allocator_macros.svh"

module bbia_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [bbia_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int AW = bbia_pkg::ALLOC_W;
   localparam int SW = bbia_pkg::STATUS_W;

   `BBIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))

   `BBIA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   `BBIA_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid,
                    rsp_tdata[AW+SW-1:AW] == bbia_pkg::ST_DONE
                    || rsp_tdata[AW+SW-1:AW] == bbia_pkg::ST_FULL
                    || rsp_tdata[AW+SW-1:AW] == bbia_pkg::ST_INVALID)

   `BBIA_ASSERT_NOW(a_fail_zero, clock, reset,
                    rsp_tvalid && rsp_tdata[AW+SW-1:AW] != bbia_pkg::ST_DONE,
                    rsp_tdata[AW-1:0] == '0)

   `BBIA_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid,
                    rsp_tdata[bbia_pkg::RSP_W-1:AW+SW] == '0)

endmodule

bind bitmap_block_inode_allocator bbia_checker u_bbia_checker (.*);
